>>> src/spl_pkg.sv
// Shared types and codes for the sorted priority list unit.
// No dependencies; imported by spl_ram and sorted_priority_list_unit.
package spl_pkg;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REM_KEY  = 3'd1,
    OP_REM_IDX  = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_READ     = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_ORDER_DESC  = 2'd0,
    REG_KEEP_SORTED = 2'd1,
    REG_FAST_FIND   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_MOVE,
    S_PUT,
    S_FAST,
    S_RDWAIT,
    S_FIN
  } state_e;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned PrioW = 32;
  localparam int unsigned EntW  = KeyW + PrioW;

endpackage

>>> src/sorted_priority_list_unit.sv
// Sorted priority list: bounded list of unique keys with 16.16 priorities.
// Contains, add and remove-key scan every stored entry; add then shifts the entries from
// the insert slot on up by one, removal shifts the later entries down or, in fast unsorted
// mode, moves the last entry into the gap; read fetches one entry; clear empties the list.
// One item in flight; the next is taken the cycle after its result is loaded.
// Reset (async, active low) empties the list and restores the config defaults.
// Uses spl_pkg and spl_ram.
module sorted_priority_list_unit #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 opcode_i,
  input  logic [spl_pkg::KeyW-1:0]   key_i,
  input  logic signed [spl_pkg::PrioW-1:0] priority_req_i,
  input  logic [5:0]                 position_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic                       found_o,
  output logic [spl_pkg::KeyW-1:0]   key_out_o,
  output logic signed [spl_pkg::PrioW-1:0] priority_out_o,
  output logic [CW-1:0]              fill_count_o,
  // config write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic                       cfg_data_i
);
  import spl_pkg::*;

  state_e state_q, state_d;

  // config
  logic desc_q, sorted_q, fast_q;

  // latched item
  logic [2:0]       op_q;
  logic [KeyW-1:0]  key_q;
  logic [PrioW-1:0] prio_q;
  logic [5:0]       pos_q;

  // list control
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          hit_q, hit_d, ins_q, ins_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d, ins_idx_q, ins_idx_d;
  logic [AW-1:0] tgt_q, tgt_d;      // insert slot or removal gap
  logic [AW-1:0] mv_q, mv_d;        // next move read address
  logic [CW-1:0] mv_left_q, mv_left_d;
  logic          mv_up_q, mv_up_d;

  // result staging and output register
  status_e         res_st_q, res_st_d;
  logic            res_fnd_q, res_fnd_d;
  logic [KeyW-1:0] res_key_q, res_key_d;
  logic [PrioW-1:0] res_prio_q, res_prio_d;
  logic            out_valid_q, out_valid_d;
  logic [2:0]      out_st_q;
  logic            out_fnd_q;
  logic [KeyW-1:0] out_key_q;
  logic [PrioW-1:0] out_prio_q;
  logic [CW-1:0]   out_cnt_q;

  // memory port
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [EntW-1:0] mem_wd, mem_rd;
  logic            rd_v_q;
  logic [AW-1:0]   rd_addr_q;
  logic [KeyW-1:0]  rd_key;
  logic [PrioW-1:0] rd_prio;

  // decoded conditions
  logic          accept, out_free, load_out;
  logic          pos_ok, full, key_null, fast_rm, cmp_hit, scan_issue, rm_ok;
  logic [AW-1:0] pos_idx, last_idx, add_idx, rem_idx, cnt_idx;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_FIN) && out_free;

  assign rd_key  = mem_rd[EntW-1:PrioW];
  assign rd_prio = mem_rd[PrioW-1:0];

  assign pos_ok   = 32'(pos_q) < 32'(count_q);
  assign pos_idx  = AW'(pos_q);
  assign full     = count_q == CW'(DEPTH);
  assign key_null = key_q == '0;
  assign fast_rm  = fast_q && !sorted_q;
  assign cnt_idx  = AW'(count_q);
  assign last_idx = AW'(count_q - CW'(1));
  assign add_idx  = (sorted_q && ins_q) ? ins_idx_q : cnt_idx;
  assign rem_idx  = (op_q == OP_REM_KEY) ? hit_idx_q : pos_idx;
  // removal proceeds when the key was found or the position is in range
  assign rm_ok    = (op_q == OP_REM_KEY) ? (!key_null && hit_q) : pos_ok;
  // insertion point: first entry at or past the new priority in list order
  assign cmp_hit  = desc_q ? ($signed(rd_prio) <= $signed(prio_q))
                           : ($signed(rd_prio) >= $signed(prio_q));
  assign scan_issue = scan_q != count_q;

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_ADD || opcode_i == OP_REM_KEY || opcode_i == OP_CONTAINS) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_SCAN: begin
        if (!scan_issue && !rd_v_q) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_FIN;
        case (op_q)
          OP_ADD: begin
            if (!key_null && !hit_q && !full) begin
              state_d = (add_idx == cnt_idx) ? S_PUT : S_MOVE;
            end
          end
          OP_REM_KEY, OP_REM_IDX: begin
            if (rm_ok && rem_idx != last_idx) begin
              state_d = fast_rm ? S_FAST : S_MOVE;
            end
          end
          OP_READ: begin
            if (pos_ok) begin
              state_d = S_RDWAIT;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_MOVE: begin
        if (mv_left_q == '0 && !rd_v_q) begin
          state_d = mv_up_q ? S_PUT : S_FIN;
        end
      end
      S_PUT:    state_d = S_FIN;
      S_FAST:   state_d = S_FIN;
      S_RDWAIT: state_d = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- datapath control ----------------
  always_comb begin
    count_d    = count_q;
    scan_d     = scan_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    ins_d      = ins_q;
    ins_idx_d  = ins_idx_q;
    tgt_d      = tgt_q;
    mv_d       = mv_q;
    mv_left_d  = mv_left_q;
    mv_up_d    = mv_up_q;
    res_st_d   = res_st_q;
    res_fnd_d  = res_fnd_q;
    res_key_d  = res_key_q;
    res_prio_d = res_prio_q;
    mem_we     = 1'b0;
    mem_wa     = rd_addr_q;
    mem_wd     = mem_rd;
    mem_re     = 1'b0;
    mem_ra     = mv_q;

    unique case (state_q)
      S_IDLE: begin
        scan_d     = '0;
        hit_d      = 1'b0;
        ins_d      = 1'b0;
        res_st_d   = ST_OK;
        res_fnd_d  = 1'b0;
        res_key_d  = '0;
        res_prio_d = '0;
      end
      S_SCAN: begin
        if (scan_issue) begin
          mem_re = 1'b1;
          mem_ra = AW'(scan_q);
          scan_d = scan_q + CW'(1);
        end
        if (rd_v_q) begin
          if (!hit_q && rd_key == key_q) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_addr_q;
          end
          if (!ins_q && cmp_hit) begin
            ins_d     = 1'b1;
            ins_idx_d = rd_addr_q;
          end
        end
      end
      S_EVAL: begin
        case (op_q)
          OP_ADD: begin
            if (key_null)   res_st_d = ST_NOT_FOUND;
            else if (hit_q) res_st_d = ST_DUP;
            else if (full)  res_st_d = ST_FULL;
            else begin
              tgt_d     = add_idx;
              mv_up_d   = 1'b1;
              mv_d      = last_idx;
              mv_left_d = count_q - CW'(add_idx);
            end
          end
          OP_REM_KEY, OP_REM_IDX: begin
            if (rm_ok) begin
              res_fnd_d = 1'b1;
              count_d   = count_q - CW'(1);
              tgt_d     = rem_idx;
              mv_up_d   = 1'b0;
              mv_d      = rem_idx + AW'(1);
              mv_left_d = CW'(last_idx) - CW'(rem_idx);
              if (fast_rm) begin
                // pull the last entry into the gap
                mem_re = 1'b1;
                mem_ra = last_idx;
              end
            end else begin
              res_st_d = (op_q == OP_REM_KEY) ? ST_NOT_FOUND : ST_RANGE;
            end
          end
          OP_CONTAINS: begin
            if (!key_null && hit_q) res_fnd_d = 1'b1;
            else                    res_st_d  = ST_NOT_FOUND;
          end
          OP_READ: begin
            if (pos_ok) begin
              mem_re = 1'b1;
              mem_ra = pos_idx;
            end else begin
              res_st_d = ST_RANGE;
            end
          end
          OP_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      S_MOVE: begin
        // read one entry a cycle, write it one slot over the next cycle
        if (mv_left_q != '0) begin
          mem_re    = 1'b1;
          mem_ra    = mv_q;
          mv_d      = mv_up_q ? (mv_q - AW'(1)) : (mv_q + AW'(1));
          mv_left_d = mv_left_q - CW'(1);
        end
        if (rd_v_q) begin
          mem_we = 1'b1;
          mem_wa = mv_up_q ? (rd_addr_q + AW'(1)) : (rd_addr_q - AW'(1));
        end
      end
      S_PUT: begin
        mem_we  = 1'b1;
        mem_wa  = tgt_q;
        mem_wd  = {key_q, prio_q};
        count_d = count_q + CW'(1);
      end
      S_FAST: begin
        mem_we = 1'b1;
        mem_wa = tgt_q;
      end
      S_RDWAIT: begin
        res_fnd_d  = 1'b1;
        res_key_d  = rd_key;
        res_prio_d = rd_prio;
      end
      S_FIN: ;
      default: ;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
      desc_q      <= 1'b1;
      sorted_q    <= 1'b0;
      fast_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_v_q      <= mem_re;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ORDER_DESC:  desc_q   <= cfg_data_i;
          REG_KEEP_SORTED: sorted_q <= cfg_data_i;
          REG_FAST_FIND:   fast_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      key_q  <= key_i;
      prio_q <= priority_req_i;
      pos_q  <= position_i;
    end
    rd_addr_q  <= mem_ra;
    scan_q     <= scan_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    ins_q      <= ins_d;
    ins_idx_q  <= ins_idx_d;
    tgt_q      <= tgt_d;
    mv_q       <= mv_d;
    mv_left_q  <= mv_left_d;
    mv_up_q    <= mv_up_d;
    res_st_q   <= res_st_d;
    res_fnd_q  <= res_fnd_d;
    res_key_q  <= res_key_d;
    res_prio_q <= res_prio_d;
    if (load_out) begin
      out_st_q   <= res_st_q;
      out_fnd_q  <= res_fnd_q;
      out_key_q  <= res_key_q;
      out_prio_q <= res_prio_q;
      out_cnt_q  <= count_q;
    end
  end

  spl_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i (clk_i),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .re_i  (mem_re),
    .ra_i  (mem_ra),
    .rd_o  (mem_rd)
  );

  assign in_stall_o     = state_q != S_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign found_o        = out_fnd_q;
  assign key_out_o      = out_key_q;
  assign priority_out_o = out_prio_q;
  assign fill_count_o   = out_cnt_q;

  // ---------------- assertions ----------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count beyond depth");

  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PUT |-> !full)
    else $error("insert into a full list");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_MOVE || state_q == S_PUT || state_q == S_FAST))
    else $error("entry write outside a modify phase");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted transfer not processed");

endmodule

>>> src/spl_ram.sv
// Entry store: one write port, one read port, registered read data.
// Depends on spl_pkg for the entry width.
module spl_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            wa_i,
  input  logic [spl_pkg::EntW-1:0] wd_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            ra_i,
  output logic [spl_pkg::EntW-1:0] rd_o
);
  import spl_pkg::*;

  logic [EntW-1:0] mem [DEPTH];
  logic [EntW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

>>> tb/sorted_priority_list_unit_tb.sv
// Testbench for sorted_priority_list_unit: directed table plus random phases under
// all settings of the three config registers, checked against an in-bench list model.
// Depends on spl_pkg and the RTL of sorted_priority_list_unit.
module sorted_priority_list_unit_tb;
  import spl_pkg::*;

  localparam int unsigned Depth    = 64;
  localparam int unsigned NumRand  = 1430;
  localparam int unsigned Settle   = 140;  // worst-case item latency, with margin
  localparam logic [2:0]  OpSpare6 = 3'd6;
  localparam logic [2:0]  OpSpare7 = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] key;
    logic [31:0] prio;
    logic [6:0]  fill;
  } resp_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] key;
    logic [31:0] prio;
    logic [5:0]  pos;
    bit          typed;  // use the row's own expected response
    resp_t       resp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] opcode_i = '0;
  logic [31:0] key_i = '0;
  logic signed [31:0] priority_req_i = '0;
  logic [5:0] position_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic found_o;
  logic [31:0] key_out_o;
  logic signed [31:0] priority_out_o;
  logic [6:0] fill_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic cfg_data_i = 1'b0;

  sorted_priority_list_unit #(.DEPTH(Depth)) dut (.*);

  always #5 clk_i = ~clk_i;

  // List model state and its copy of the config registers
  logic [31:0] lst_key [Depth];
  logic [31:0] lst_prio[Depth];
  int unsigned lst_cnt;
  bit cur_desc, cur_sorted, cur_fast;

  resp_t pending_resp[$];
  int    errors;
  bit    quiet;       // no idling on either side
  bit    hold_req;    // ask the receiver for one long hold-off

  function automatic int find_entry(logic [31:0] k);
    for (int i = 0; i < lst_cnt; i++)
      if (lst_key[i] == k) return i;
    return lst_cnt;
  endfunction

  function automatic void drop_entry(int idx);
    int last;
    last = lst_cnt - 1;
    if (cur_fast && !cur_sorted) begin
      lst_key[idx]  = lst_key[last];
      lst_prio[idx] = lst_prio[last];
    end else begin
      for (int i = idx; i < last; i++) begin
        lst_key[i]  = lst_key[i+1];
        lst_prio[i] = lst_prio[i+1];
      end
    end
    lst_cnt = last;
  endfunction

  // Applies one operation to the model and returns the response it should give
  function automatic resp_t list_apply(logic [2:0] op, logic [31:0] k,
                                       logic [31:0] p, logic [5:0] pos);
    resp_t r;
    int idx;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ADD: begin
        if (k == 0) r.status = ST_NOT_FOUND;
        else if (find_entry(k) < lst_cnt) r.status = ST_DUP;
        else if (lst_cnt >= Depth) r.status = ST_FULL;
        else begin
          idx = lst_cnt;
          if (cur_sorted)
            for (int i = 0; i < lst_cnt; i++)
              if (cur_desc ? ($signed(lst_prio[i]) <= $signed(p))
                           : ($signed(lst_prio[i]) >= $signed(p))) begin
                idx = i;
                break;
              end
          for (int i = lst_cnt; i > idx; i--) begin
            lst_key[i]  = lst_key[i-1];
            lst_prio[i] = lst_prio[i-1];
          end
          lst_key[idx]  = k;
          lst_prio[idx] = p;
          lst_cnt++;
        end
      end
      OP_REM_KEY: begin
        idx = (k == 0) ? lst_cnt : find_entry(k);
        if (idx < lst_cnt) begin
          drop_entry(idx);
          r.found = 1'b1;
        end else r.status = ST_NOT_FOUND;
      end
      OP_REM_IDX: begin
        if (pos < lst_cnt) begin
          drop_entry(pos);
          r.found = 1'b1;
        end else r.status = ST_RANGE;
      end
      OP_CONTAINS: begin
        if (k != 0 && find_entry(k) < lst_cnt) r.found = 1'b1;
        else r.status = ST_NOT_FOUND;
      end
      OP_READ: begin
        if (pos < lst_cnt) begin
          r.found = 1'b1;
          r.key   = lst_key[pos];
          r.prio  = lst_prio[pos];
        end else r.status = ST_RANGE;
      end
      OP_CLEAR: lst_cnt = 0;
      default: ;  // spare opcodes do nothing
    endcase
    r.fill = lst_cnt[6:0];
    return r;
  endfunction

  // Offers one item; returns after the transfer, with the expectation queued
  task automatic send_item(logic [2:0] op, logic [31:0] k, logic [31:0] p,
                           logic [5:0] pos, bit typed, resp_t tr);
    resp_t r;
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    key_i          <= k;
    priority_req_i <= p;
    position_i     <= pos;
    do @(posedge clk_i); while (in_stall_o);
    r = list_apply(op, k, p, pos);
    pending_resp.push_back(typed ? tr : r);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, bit val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ORDER_DESC:  cur_desc   = val;
      REG_KEEP_SORTED: cur_sorted = val;
      default:         cur_fast   = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return 32'd0;
    if (sel < 10) return $urandom();
    if (sel < 13) return 32'hFFFF_FF00 | $urandom_range(0, 7);
    return $urandom_range(1, 90);
  endfunction

  function automatic logic [31:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 32'h8000_0000;
    if (sel == 1) return 32'h7FFF_FFFF;
    if (sel < 5) return {16'($signed($urandom_range(0, 6)) - 3), 16'h0};  // ties
    return $urandom();
  endfunction

  // Result side: random stall bursts, one long hold on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    resp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_resp.size() == 0) begin
        $error("result with no pending expectation");
        errors++;
      end else begin
        e = pending_resp.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (found_o !== e.found) begin
          $error("found exp %0d got %0d", e.found, found_o); errors++;
        end
        if (key_out_o !== e.key) begin
          $error("key_out exp %h got %h", e.key, key_out_o); errors++;
        end
        if (priority_out_o !== e.prio) begin
          $error("priority_out exp %h got %h", e.prio, priority_out_o); errors++;
        end
        if (fill_count_o !== e.fill) begin
          $error("fill_count exp %0d got %0d", e.fill, fill_count_o); errors++;
        end
      end
    end
  end

  initial begin
    #30000000;
    $display("FAIL");
    $finish;
  end

  // Directed rows; typed responses assume the reset config (append, shift removal)
  function automatic row_t mk(logic [2:0] op, logic [31:0] k, logic [31:0] p,
                              logic [5:0] pos, bit typed = 0,
                              logic [2:0] st = ST_OK, bit fd = 0,
                              logic [31:0] ko = 0, logic [31:0] po = 0,
                              logic [6:0] fl = 0);
    row_t r;
    r.op = op; r.key = k; r.prio = p; r.pos = pos; r.typed = typed;
    r.resp = '{status: st, found: fd, key: ko, prio: po, fill: fl};
    return r;
  endfunction

  initial begin
    row_t rows[$];
    int phase, n_items, sel;
    logic [2:0] op;
    logic [5:0] pos;
    bit [2:0] combo;
    errors = 0; lst_cnt = 0; quiet = 0; hold_req = 0;
    cur_desc = 1; cur_sorted = 0; cur_fast = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    rows.push_back(mk(OP_READ,     0, 0, 0, 1, ST_RANGE, 0, 0, 0, 0));
    rows.push_back(mk(OP_ADD,      0, 5, 0, 1, ST_NOT_FOUND, 0, 0, 0, 0));
    rows.push_back(mk(OP_ADD,      32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1, ST_OK, 0, 0, 0, 1));
    rows.push_back(mk(OP_ADD,      32'hFFFF_FFFF, 1, 0, 1, ST_DUP, 0, 0, 0, 1));
    rows.push_back(mk(OP_ADD,      1, 32'h8000_0000, 0, 1, ST_OK, 0, 0, 0, 2));
    rows.push_back(mk(OP_READ,     0, 0, 0, 1, ST_OK, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 2));
    rows.push_back(mk(OP_READ,     0, 0, 1, 1, ST_OK, 1, 1, 32'h8000_0000, 2));
    rows.push_back(mk(OP_READ,     0, 0, 63, 1, ST_RANGE, 0, 0, 0, 2));
    rows.push_back(mk(OP_CONTAINS, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 2));
    rows.push_back(mk(OP_CONTAINS, 32'hFFFF_FFFF, 0, 0, 1, ST_OK, 1, 0, 0, 2));
    rows.push_back(mk(OP_REM_KEY,  5, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 2));
    rows.push_back(mk(OP_REM_KEY,  0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0, 2));
    rows.push_back(mk(OP_REM_IDX,  0, 0, 63, 1, ST_RANGE, 0, 0, 0, 2));
    rows.push_back(mk(OpSpare6,    7, 7, 7, 1, ST_OK, 0, 0, 0, 2));
    rows.push_back(mk(OpSpare7,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 63, 1, ST_OK, 0, 0, 0, 2));
    rows.push_back(mk(OP_ADD,      2, 32'h0001_8000, 0));
    rows.push_back(mk(OP_REM_IDX,  0, 0, 0));
    rows.push_back(mk(OP_READ,     0, 0, 0));
    rows.push_back(mk(OP_REM_KEY,  1, 0, 0));
    rows.push_back(mk(OP_CLEAR,    0, 0, 0, 1, ST_OK, 0, 0, 0, 0));
    foreach (rows[i])
      send_item(rows[i].op, rows[i].key, rows[i].prio, rows[i].pos,
                rows[i].typed, rows[i].resp);
    wait_drained();

    // Random phases; each one visits a config setting, all eight included
    n_items = 0;
    for (phase = 0; n_items < NumRand; phase++) begin
      combo = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
      cfg_write(REG_ORDER_DESC, combo[0]);
      cfg_write(REG_KEEP_SORTED, combo[1]);
      cfg_write(REG_FAST_FIND, combo[2]);
      for (int j = 0; j < 160 && n_items < NumRand; j++, n_items++) begin
        if (n_items > NumRand - 150) quiet = 1;
        if (n_items == 300) hold_req = 1;
        if (n_items == 600) wait_drained();
        sel = $urandom_range(0, 99);
        // Odd phases lean on adds so the list fills up and reports full
        if (sel < ((phase % 2) ? 65 : 35)) op = OP_ADD;
        else if (sel < 72) op = OP_REM_KEY;
        else if (sel < 80) op = OP_REM_IDX;
        else if (sel < 87) op = OP_CONTAINS;
        else if (sel < 96) op = OP_READ;
        else if (sel < 98) op = OP_CLEAR;
        else op = sel[0] ? OpSpare6 : OpSpare7;
        if (lst_cnt > 0 && $urandom_range(0, 1)) pos = 6'($urandom_range(0, lst_cnt - 1));
        else pos = 6'($urandom_range(0, 63));
        send_item(op, pick_key(), pick_prio(), pos, 0, '0);
      end
      wait_drained();
    end

    repeat (Settle) @(negedge clk_i);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
